// File: src/rgb_hue_color_classifier_macros.svh
// Assertion macros shared by the checker of the hue classifier
`ifndef RGB_HUE_COLOR_CLASSIFIER_MACROS_SVH
`define RGB_HUE_COLOR_CLASSIFIER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define RHC_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("rhc assertion failed");

// Check that a condition implies a consequence in the next cycle
`define RHC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("rhc assertion failed");

`endif

// File: src/rhc_pkg.sv
// Types, constants and the colour class ladder for the hue classifier
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int DIV_STEPS = 8;

    localparam logic [7:0] HUE_SPAN = 8'd43;
    localparam logic [7:0] BASE_RED = 8'd0;
    localparam logic [7:0] BASE_GREEN = 8'd85;
    localparam logic [7:0] BASE_BLUE = 8'd171;

    localparam logic [7:0] SAT_WHITE_LIMIT = 8'd80;
    localparam logic [7:0] HUE_RED_END = 8'd32;
    localparam logic [7:0] HUE_RED_GREEN_END = 8'd52;
    localparam logic [7:0] HUE_GREEN_END = 8'd118;
    localparam logic [7:0] HUE_BLUE_GREEN_END = 8'd149;
    localparam logic [7:0] HUE_BLUE_END = 8'd193;
    localparam logic [7:0] HUE_RED_BLUE_END = 8'd223;

    localparam logic [2:0] CLS_WHITE = 3'd0;
    localparam logic [2:0] CLS_RED = 3'd1;
    localparam logic [2:0] CLS_RED_GREEN = 3'd2;
    localparam logic [2:0] CLS_GREEN = 3'd3;
    localparam logic [2:0] CLS_BLUE_GREEN = 3'd4;
    localparam logic [2:0] CLS_BLUE = 3'd5;
    localparam logic [2:0] CLS_RED_BLUE = 3'd6;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] d;
        sector_t    sector;
        logic       neg;
        logic [7:0] sat_rem;
        logic [7:0] sat_acc;
        logic [7:0] hue_rem;
        logic [7:0] hue_acc;
    } div_t;

    typedef struct packed {
        logic [4:0] pad;
        logic [2:0] color_class;
        logic [7:0] brightness;
        logic [7:0] saturation;
        logic [7:0] hue;
    } result_t;

    function automatic logic [2:0] classify(logic [7:0] hue, logic [7:0] sat);
        logic [2:0] cls;
        if (sat < SAT_WHITE_LIMIT) cls = CLS_WHITE;
        else if (hue < HUE_RED_END) cls = CLS_RED;
        else if (hue < HUE_RED_GREEN_END) cls = CLS_RED_GREEN;
        else if (hue < HUE_GREEN_END) cls = CLS_GREEN;
        else if (hue < HUE_BLUE_GREEN_END) cls = CLS_BLUE_GREEN;
        else if (hue < HUE_BLUE_END) cls = CLS_BLUE;
        else if (hue < HUE_RED_BLUE_END) cls = CLS_RED_BLUE;
        else cls = CLS_RED;
        return cls;
    endfunction

endpackage

// File: src/rhc_front.sv
// Front stages: channel max/min, sector pick, then divider operands
`timescale 1ns / 1ps

module rhc_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rhc_pkg::pixel_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rhc_pkg::div_t  out_data
);

    logic              a_valid_reg;
    logic              a_ready;
    logic [7:0]        a_hi_reg;
    logic [7:0]        a_lo_reg;
    rhc_pkg::sector_t  a_sector_reg;
    logic [8:0]        a_diff_reg;

    logic [7:0]        a_hi_next;
    logic [7:0]        a_lo_next;
    rhc_pkg::sector_t  a_sector_next;
    logic [8:0]        a_diff_next;

    logic              b_valid_reg;
    logic              b_ready;
    rhc_pkg::div_t     b_data_reg;
    rhc_pkg::div_t     b_data_next;

    logic [7:0]        d;
    logic              neg;
    logic [8:0]        neg_diff;
    logic [7:0]        abs_diff;
    logic [15:0]       num_sat;
    logic [15:0]       num_hue;

    always_comb
    begin
        if (in_data.red >= in_data.green && in_data.red >= in_data.blue)
        begin
            a_hi_next     = in_data.red;
            a_sector_next = rhc_pkg::SEC_RED;
            a_diff_next   = {1'b0, in_data.green} - {1'b0, in_data.blue};
        end
        else if (in_data.green >= in_data.blue)
        begin
            a_hi_next     = in_data.green;
            a_sector_next = rhc_pkg::SEC_GREEN;
            a_diff_next   = {1'b0, in_data.blue} - {1'b0, in_data.red};
        end
        else
        begin
            a_hi_next     = in_data.blue;
            a_sector_next = rhc_pkg::SEC_BLUE;
            a_diff_next   = {1'b0, in_data.red} - {1'b0, in_data.green};
        end

        if (in_data.red <= in_data.green && in_data.red <= in_data.blue)
            a_lo_next = in_data.red;
        else if (in_data.green <= in_data.blue)
            a_lo_next = in_data.green;
        else
            a_lo_next = in_data.blue;
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_hi_reg     <= a_hi_next;
            a_lo_reg     <= a_lo_next;
            a_sector_reg <= a_sector_next;
            a_diff_reg   <= a_diff_next;
        end
    end

    always_comb
    begin
        d        = a_hi_reg - a_lo_reg;
        neg      = a_diff_reg[8];
        neg_diff = 9'd0 - a_diff_reg;
        abs_diff = neg ? neg_diff[7:0] : a_diff_reg[7:0];
        num_sat  = {d, 8'h00} - {8'h00, d};
        num_hue  = 16'(abs_diff) * 16'(rhc_pkg::HUE_SPAN);

        b_data_next.hi      = a_hi_reg;
        b_data_next.d       = d;
        b_data_next.sector  = a_sector_reg;
        b_data_next.neg     = neg;
        b_data_next.sat_rem = num_sat[15:8];
        b_data_next.sat_acc = num_sat[7:0];
        b_data_next.hue_rem = num_hue[15:8];
        b_data_next.hue_acc = num_hue[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
            b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// File: src/rhc_div_stage.sv
// One restoring division step for both saturation and hue quotients
`timescale 1ns / 1ps

module rhc_div_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rhc_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rhc_pkg::div_t out_data
);

    logic          valid_reg;
    rhc_pkg::div_t data_reg;
    rhc_pkg::div_t data_next;

    logic [8:0]    sat_trial;
    logic [8:0]    sat_diff;
    logic          sat_ge;
    logic [8:0]    hue_trial;
    logic [8:0]    hue_diff;
    logic          hue_ge;

    always_comb
    begin
        sat_trial = {in_data.sat_rem, in_data.sat_acc[7]};
        sat_diff  = sat_trial - {1'b0, in_data.hi};
        sat_ge    = sat_trial >= {1'b0, in_data.hi};
        hue_trial = {in_data.hue_rem, in_data.hue_acc[7]};
        hue_diff  = hue_trial - {1'b0, in_data.d};
        hue_ge    = hue_trial >= {1'b0, in_data.d};

        data_next         = in_data;
        data_next.sat_rem = sat_ge ? sat_diff[7:0] : sat_trial[7:0];
        data_next.sat_acc = {in_data.sat_acc[6:0], sat_ge};
        data_next.hue_rem = hue_ge ? hue_diff[7:0] : hue_trial[7:0];
        data_next.hue_acc = {in_data.hue_acc[6:0], hue_ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/rhc_back.sv
// Back stages: signed hue assembly, then colour classification
`timescale 1ns / 1ps

module rhc_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rhc_pkg::div_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rhc_pkg::result_t out_data
);

    logic             h_valid_reg;
    logic             h_ready;
    logic [7:0]       h_hue_reg;
    logic [7:0]       h_sat_reg;
    logic [7:0]       h_bright_reg;
    logic [7:0]       h_hue_next;
    logic [7:0]       h_sat_next;
    logic [7:0]       base;
    logic [7:0]       offset;

    logic             r_valid_reg;
    logic             r_ready;
    rhc_pkg::result_t r_data_reg;
    rhc_pkg::result_t r_data_next;

    always_comb
    begin
        case (in_data.sector)
            rhc_pkg::SEC_RED:   base = rhc_pkg::BASE_RED;
            rhc_pkg::SEC_GREEN: base = rhc_pkg::BASE_GREEN;
            rhc_pkg::SEC_BLUE:  base = rhc_pkg::BASE_BLUE;
            default:            base = rhc_pkg::BASE_RED;
        endcase
        offset = in_data.neg ? (8'd0 - in_data.hue_acc) : in_data.hue_acc;
        if (in_data.d == 8'd0)
        begin
            h_hue_next = 8'd0;
            h_sat_next = 8'd0;
        end
        else
        begin
            h_hue_next = base + offset;
            h_sat_next = in_data.sat_acc;
        end
    end

    assign r_ready  = !r_valid_reg || out_ready;
    assign h_ready  = !h_valid_reg || r_ready;
    assign in_ready = h_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (h_ready)
            h_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (h_ready && in_valid)
        begin
            h_hue_reg    <= h_hue_next;
            h_sat_reg    <= h_sat_next;
            h_bright_reg <= in_data.hi;
        end
    end

    always_comb
    begin
        r_data_next.pad         = '0;
        r_data_next.color_class = rhc_pkg::classify(h_hue_reg, h_sat_reg);
        r_data_next.brightness  = h_bright_reg;
        r_data_next.saturation  = h_sat_reg;
        r_data_next.hue         = h_hue_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (r_ready)
            r_valid_reg <= h_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r_ready && h_valid_reg)
            r_data_reg <= r_data_next;
    end

    assign out_valid = r_valid_reg;
    assign out_data  = r_data_reg;

endmodule

// File: src/rgb_hue_color_classifier.sv
// Throughput: one pixel per cycle while the output is not stalled; two front stages,
// eight division steps (one quotient bit per stage for both dividers) and two back
// stages.
// Each stage holds its own valid bit, so bubbles collapse while the output stalls.
// Reset: asynchronous, active low; clears every valid bit, no clearing pass.
`timescale 1ns / 1ps

module rgb_hue_color_classifier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // hue[7:0], saturation[15:8], brightness[23:16],
                                  // color_class[26:24], zero[31:27]
);

    logic             div_valid [0:rhc_pkg::DIV_STEPS];
    logic             div_ready [0:rhc_pkg::DIV_STEPS];
    rhc_pkg::div_t    div_data  [0:rhc_pkg::DIV_STEPS];
    rhc_pkg::result_t result;

    rhc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (rhc_pkg::pixel_t'(s_tdata)),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar i = 0; i < rhc_pkg::DIV_STEPS; i++)
    begin : g_div
        rhc_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    rhc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[rhc_pkg::DIV_STEPS]),
        .in_ready  (div_ready[rhc_pkg::DIV_STEPS]),
        .in_data   (div_data[rhc_pkg::DIV_STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = result;

endmodule

// File: src/rhc_checker.sv
// Port-level checker for the hue classifier and its bind
`timescale 1ns / 1ps
`include "rgb_hue_color_classifier_macros.svh"

module rhc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic stalled;
    logic low_sat;
    logic is_white;
    logic sat_zero;
    logic hue_zero;
    logic bright_zero;
    logic pad_ok;

    assign stalled     = m_tvalid && !m_tready;
    assign low_sat     = m_tdata[15:8] < rhc_pkg::SAT_WHITE_LIMIT;
    assign is_white    = m_tdata[26:24] == rhc_pkg::CLS_WHITE;
    assign sat_zero    = m_tdata[15:8] == 8'd0;
    assign hue_zero    = m_tdata[7:0] == 8'd0;
    assign bright_zero = m_tdata[23:16] == 8'd0;
    assign pad_ok      = m_tdata[31:27] == 5'd0 && m_tdata[26:24] != 3'd7;

    `RHC_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, m_tvalid && $stable(m_tdata))
    `RHC_ASSERT_SAME(a_low_sat_white, clk, rst_n, m_tvalid && low_sat, is_white)
    `RHC_ASSERT_SAME(a_gray_hue_zero, clk, rst_n, m_tvalid && sat_zero, hue_zero)
    `RHC_ASSERT_SAME(a_black_sat_zero, clk, rst_n, m_tvalid && bright_zero, sat_zero)
    `RHC_ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, pad_ok)

endmodule

bind rgb_hue_color_classifier rhc_checker u_rhc_checker (.*);

// File: sim/rgb_hue_color_classifier_test.sv
// Self-checking testbench for the RGB to HSV colour classifier: stream stimulus and scoreboard
`timescale 1ns / 1ps

module rgb_hue_color_classifier_test;

    localparam int IDLE_LIMIT = 1000;
    localparam int LONG_HOLD = 64;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES = 8;
    localparam int SETTLE_CYCLES = 20;

    class hsv_scoreboard;
        rhc_pkg::result_t hsv_q[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function logic [2:0] colour_group(logic [7:0] hue, logic [7:0] sat);
            if (sat < rhc_pkg::SAT_WHITE_LIMIT) return rhc_pkg::CLS_WHITE;
            if (hue >= rhc_pkg::HUE_RED_BLUE_END) return rhc_pkg::CLS_RED;
            if (hue >= rhc_pkg::HUE_BLUE_END) return rhc_pkg::CLS_RED_BLUE;
            if (hue >= rhc_pkg::HUE_BLUE_GREEN_END) return rhc_pkg::CLS_BLUE;
            if (hue >= rhc_pkg::HUE_GREEN_END) return rhc_pkg::CLS_BLUE_GREEN;
            if (hue >= rhc_pkg::HUE_RED_GREEN_END) return rhc_pkg::CLS_GREEN;
            if (hue >= rhc_pkg::HUE_RED_END) return rhc_pkg::CLS_RED_GREEN;
            return rhc_pkg::CLS_RED;
        endfunction

        function rhc_pkg::result_t hsv_of(rhc_pkg::pixel_t p);
            int hi;
            int lo;
            int d;
            int diff;
            int base;
            int q;
            rhc_pkg::result_t res;
            hi = int'(p.red);
            if (int'(p.green) > hi) hi = int'(p.green);
            if (int'(p.blue) > hi) hi = int'(p.blue);
            lo = int'(p.red);
            if (int'(p.green) < lo) lo = int'(p.green);
            if (int'(p.blue) < lo) lo = int'(p.blue);
            d = hi - lo;
            res = '0;
            res.brightness = 8'(hi);
            if (hi != 0) res.saturation = 8'((255 * d) / hi);
            if (res.saturation != 0 && d != 0)
            begin
                if (hi == int'(p.red))
                begin
                    base = int'(rhc_pkg::BASE_RED);
                    diff = int'(p.green) - int'(p.blue);
                end
                else if (hi == int'(p.green))
                begin
                    base = int'(rhc_pkg::BASE_GREEN);
                    diff = int'(p.blue) - int'(p.red);
                end
                else
                begin
                    base = int'(rhc_pkg::BASE_BLUE);
                    diff = int'(p.red) - int'(p.green);
                end
                q = (int'(rhc_pkg::HUE_SPAN) * diff) / d;
                res.hue = 8'(base + q + 256);
            end
            res.color_class = colour_group(res.hue, res.saturation);
            return res;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function void note_pixel(rhc_pkg::pixel_t p);
            hsv_q.push_back(hsv_of(p));
        endfunction

        task check_result(logic [31:0] data);
            rhc_pkg::result_t got;
            rhc_pkg::result_t want;
            got = rhc_pkg::result_t'(data);
            if (hsv_q.size() == 0)
            begin
                report($sformatf("unexpected output transaction %h", data));
                return;
            end
            want = hsv_q.pop_front();
            if (got.hue != want.hue)
                report($sformatf("hue %0d, want %0d", got.hue, want.hue));
            if (got.saturation != want.saturation)
                report($sformatf("saturation %0d, want %0d", got.saturation, want.saturation));
            if (got.brightness != want.brightness)
                report($sformatf("brightness %0d, want %0d", got.brightness, want.brightness));
            if (got.color_class != want.color_class)
                report($sformatf("class %0d, want %0d", got.color_class, want.color_class));
            if (got.pad != '0)
                report($sformatf("padding bits %b not zero", got.pad));
        endtask

        function int pending();
            return hsv_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    hsv_scoreboard sb;
    int tx_gap_max;
    int rx_gap_max;
    int hold_req;
    int idle_cycles;

    rgb_hue_color_classifier dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic rhc_pkg::pixel_t rgb(int r, int g, int b);
        rhc_pkg::pixel_t p;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        return p;
    endfunction

    function automatic logic [7:0] near(logic [7:0] base);
        return base + 8'($urandom_range(6, 0)) - 8'd3;
    endfunction

    function automatic logic [7:0] extreme();
        int pick;
        pick = $urandom_range(2, 0);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic rhc_pkg::pixel_t random_pixel();
        rhc_pkg::pixel_t p;
        int kind;
        logic [7:0] base;
        kind = $urandom_range(99, 0);
        base = 8'($urandom);
        p = rhc_pkg::pixel_t'(24'($urandom));
        if (kind < 20)
        begin
            p.red = near(base);
            p.green = near(base);
            p.blue = near(base);
        end
        else if (kind < 30)
        begin
            p.green = p.red;
        end
        else if (kind < 35)
        begin
            p.blue = p.green;
        end
        else if (kind < 40)
        begin
            p.blue = p.red;
        end
        else if (kind < 55)
        begin
            p.red = extreme();
            p.green = extreme();
            p.blue = extreme();
        end
        return p;
    endfunction

    task send_pixel(rhc_pkg::pixel_t p);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = p;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    task wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() > 0) @(negedge clk);
    endtask

    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                m_tready = 1'b0;
                repeat (hold_req) @(negedge clk);
                hold_req = 0;
            end
            gap = $urandom_range(rx_gap_max, 0);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rhc_pkg::pixel_t directed[$];
        sb = new();
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        tx_gap_max = 0;
        rx_gap_max = 0;
        hold_req = 0;
        idle_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed = '{
            rgb(0, 0, 0), rgb(255, 255, 255), rgb(128, 128, 128), rgb(1, 1, 1),
            rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
            rgb(255, 255, 0), rgb(0, 255, 255), rgb(255, 0, 255),
            rgb(1, 0, 0), rgb(255, 0, 10), rgb(255, 0, 255), rgb(200, 0, 200),
            rgb(255, 176, 176), rgb(255, 175, 175), rgb(255, 254, 254),
            rgb(10, 0, 255), rgb(255, 0, 1), rgb(0, 1, 255), rgb(1, 255, 0),
            rgb(255, 130, 0), rgb(0, 255, 200), rgb(170, 0, 255), rgb(255, 255, 254)
        };
        foreach (directed[i]) send_pixel(directed[i]);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            tx_gap_max = (ph % 2 == 1) ? 0 : 3;
            rx_gap_max = (ph % 3 == 1) ? 0 : 3;
            if (ph == 3)
            begin
                tx_gap_max = 0;
                hold_req = LONG_HOLD;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(random_pixel());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.pending() > 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
